>>> rtl/core/point_to_pixel_color_splat_defines.svh
// ---------------------------------------------------------------------------
// Point to pixel color splat assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef POINT_TO_PIXEL_COLOR_SPLAT_DEFINES_SVH
`define POINT_TO_PIXEL_COLOR_SPLAT_DEFINES_SVH

`ifndef SYNTHESIS
`define PPCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppcs assertion failed");
`define PPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppcs assertion failed");
`else
`define PPCS_ASSERT_SAME(lbl, ante, cons)
`define PPCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/ppcs_pkg.sv
// ---------------------------------------------------------------------------
// Point to pixel color splat package
// Field widths, register indexes, reset values and shared types.
// ---------------------------------------------------------------------------
package ppcs_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SCALE_W     = 24;
  localparam int PRODUCT_W   = COORD_W + SCALE_W;
  localparam int FRAC_SHIFT  = 24;
  localparam int LEVEL_W     = 8;
  localparam int POS_W       = 12;
  localparam int DIM_CFG_W   = 13;
  localparam int INDEX_W     = 24;
  localparam int BOX_W       = 3 * COORD_W;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 48;

  localparam logic [LEVEL_W-1:0]   LEVEL_MAX         = 8'd255;
  localparam logic [LEVEL_W-1:0]   LEVEL_MIN         = 8'd0;
  localparam logic [SCALE_W-1:0]   SCALE_RESET       = 24'd4096;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RESET       = 13'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET      = 13'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CROP_ENABLE  = 4'd0,
    REG_BOX_MIN      = 4'd1,
    REG_BOX_MAX      = 4'd2,
    REG_SCALE_X      = 4'd3,
    REG_SCALE_Y      = 4'd4,
    REG_SCALE_Z      = 4'd5,
    REG_IMAGE_WIDTH  = 4'd6,
    REG_IMAGE_HEIGHT = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

>>> rtl/core/ppcs_if.sv
// ---------------------------------------------------------------------------
// Point to pixel color splat channel interfaces
// Point input, pixel result and configuration write channels.
// ---------------------------------------------------------------------------
interface ppcs_point_if;
  import ppcs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic signed [COORD_W-1:0]  point_z;
  logic        [POS_W-1:0]    cam_column;
  logic        [POS_W-1:0]    cam_row;
  logic                       last_point;

  modport source (output valid, point_x, point_y, point_z, cam_column, cam_row,
                  last_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, cam_column, cam_row,
                last_point, output ready);
endinterface

interface ppcs_pixel_if;
  import ppcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 write_pixel;
  logic [INDEX_W-1:0]   pixel_index;
  logic [LEVEL_W-1:0]   red;
  logic [LEVEL_W-1:0]   green;
  logic [LEVEL_W-1:0]   blue;
  logic                 end_of_cloud;

  modport source (output valid, write_pixel, pixel_index, red, green, blue,
                  end_of_cloud, input ready);
  modport sink (input valid, write_pixel, pixel_index, red, green, blue,
                end_of_cloud, output ready);
endinterface

interface ppcs_cfg_if;
  import ppcs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/point_to_pixel_color_splat.sv
// ---------------------------------------------------------------------------
// Point to pixel color splat
// Optionally crops scanned points to a box and maps them to pixel index and color.
// ---------------------------------------------------------------------------
// The point channel takes one scanned point per word: signed Q4.12 x, y, z,
// the camera column and row, and a last-point flag. The pixel channel returns
// exactly one word per point, in order: a write flag, the linear pixel index
// and the red, green and blue levels, all zero when the flag is low.
// The configuration channel is always ready and writes one register per
// word; it is to be used only while no point is in flight.
// The pipeline takes one point per clock unless the pixel channel stalls;
// its three stages are the box subtraction, the scale and dimension
// multipliers, and the clamp with the index add and range compare.
// Each stage has its own valid bit and loads whenever it is empty or its
// successor takes its word, so a stalled receiver backs words up stage by
// stage into the point channel without loss or repetition, and a bubble is
// squeezed out. Reset empties the pipeline and restores the registers.
// ---------------------------------------------------------------------------
`include "point_to_pixel_color_splat_defines.svh"

module point_to_pixel_color_splat #(
  parameter int MAX_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst,
  ppcs_point_if.sink    point,
  ppcs_pixel_if.source  pixel,
  ppcs_cfg_if.sink      cfg
);
  import ppcs_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int ROWP_W = DIM_W + POS_W;
  localparam int SUM_W  = ROWP_W + 1;
  localparam int AREA_W = 2 * DIM_W;
  localparam int CMP_W  = (SUM_W > AREA_W) ? SUM_W : AREA_W;
  localparam logic [DIM_CFG_W-1:0] DIM_LIMIT = DIM_CFG_W'(MAX_DIM);

  logic                 crop_enable;
  logic [BOX_W-1:0]     box_min_corner;
  logic [BOX_W-1:0]     box_max_corner;
  logic [SCALE_W-1:0]   scale_x;
  logic [SCALE_W-1:0]   scale_y;
  logic [SCALE_W-1:0]   scale_z;
  logic [DIM_CFG_W-1:0] image_width;
  logic [DIM_CFG_W-1:0] image_height;

  logic                 v1, v2, v3;
  logic                 ready1, ready2, ready3;
  stage_en_t            en;

  logic [DIM_W-1:0]     w_sat, h_sat;
  logic [DIM_W-1:0]     w1, h1;
  logic [POS_W-1:0]     col1, row1, col2;
  logic                 last1, last2, last3;
  logic [ROWP_W-1:0]    wrow2;
  logic [AREA_W-1:0]    area2;
  logic                 crop_ok2;
  logic [SUM_W-1:0]     sum;
  logic                 keep3;
  logic [INDEX_W-1:0]   idx3;
  logic                 out_x, out_y, out_z;
  logic [LEVEL_W-1:0]   level_x, level_y, level_z;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_enable    <= 1'b0;
      box_min_corner <= '0;
      box_max_corner <= '0;
      scale_x        <= SCALE_RESET;
      scale_y        <= SCALE_RESET;
      scale_z        <= SCALE_RESET;
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CROP_ENABLE:  crop_enable    <= cfg.data[0];
        REG_BOX_MIN:      box_min_corner <= cfg.data[BOX_W-1:0];
        REG_BOX_MAX:      box_max_corner <= cfg.data[BOX_W-1:0];
        REG_SCALE_X:      scale_x        <= cfg.data[SCALE_W-1:0];
        REG_SCALE_Y:      scale_y        <= cfg.data[SCALE_W-1:0];
        REG_SCALE_Z:      scale_z        <= cfg.data[SCALE_W-1:0];
        REG_IMAGE_WIDTH:  image_width    <= cfg.data[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height   <= cfg.data[DIM_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ready3      = !v3 || pixel.ready;
  assign ready2      = !v2 || ready3;
  assign ready1      = !v1 || ready2;
  assign point.ready = ready1;
  assign en          = '{s1: ready1, s2: ready2, s3: ready3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= point.valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  assign w_sat = (image_width > DIM_LIMIT) ? DIM_W'(MAX_DIM) : DIM_W'(image_width);
  assign h_sat = (image_height > DIM_LIMIT) ? DIM_W'(MAX_DIM) : DIM_W'(image_height);
  assign sum   = SUM_W'(col2) + SUM_W'(wrow2);

  always_ff @(posedge clk) begin
    if (ready1) begin
      w1    <= w_sat;
      h1    <= h_sat;
      col1  <= point.cam_column;
      row1  <= point.cam_row;
      last1 <= point.last_point;
    end
    if (ready2) begin
      wrow2    <= ROWP_W'(w1) * ROWP_W'(row1);
      area2    <= AREA_W'(w1) * AREA_W'(h1);
      col2     <= col1;
      last2    <= last1;
      crop_ok2 <= !(crop_enable && (out_x || out_y || out_z));
    end
    if (ready3) begin
      keep3 <= crop_ok2 && (CMP_W'(sum) < CMP_W'(area2));
      idx3  <= INDEX_W'(sum);
      last3 <= last2;
    end
  end

  ppcs_axis u_axis_x (
    .clk     (clk),
    .en      (en),
    .coord   (point.point_x),
    .lo      (box_min_corner[COORD_W-1:0]),
    .hi      (box_max_corner[COORD_W-1:0]),
    .scale   (scale_x),
    .outside (out_x),
    .level   (level_x)
  );

  ppcs_axis u_axis_y (
    .clk     (clk),
    .en      (en),
    .coord   (point.point_y),
    .lo      (box_min_corner[2*COORD_W-1:COORD_W]),
    .hi      (box_max_corner[2*COORD_W-1:COORD_W]),
    .scale   (scale_y),
    .outside (out_y),
    .level   (level_y)
  );

  ppcs_axis u_axis_z (
    .clk     (clk),
    .en      (en),
    .coord   (point.point_z),
    .lo      (box_min_corner[3*COORD_W-1:2*COORD_W]),
    .hi      (box_max_corner[3*COORD_W-1:2*COORD_W]),
    .scale   (scale_z),
    .outside (out_z),
    .level   (level_z)
  );

  assign pixel.valid        = v3;
  assign pixel.write_pixel  = keep3;
  assign pixel.pixel_index  = keep3 ? idx3 : '0;
  assign pixel.red          = keep3 ? level_x : LEVEL_MIN;
  assign pixel.green        = keep3 ? level_y : LEVEL_MIN;
  assign pixel.blue         = keep3 ? level_z : LEVEL_MIN;
  assign pixel.end_of_cloud = last3;

  `PPCS_ASSERT_NEXT(a_accept_fills_s1, point.valid && point.ready, v1)
  `PPCS_ASSERT_NEXT(a_s1_holds_on_stall, v1 && !ready2, v1)
  `PPCS_ASSERT_SAME(a_s2_stall_blocks_input, v2 && v1 && !ready3, !point.ready)

endmodule

>>> rtl/core/ppcs_axis.sv
// ---------------------------------------------------------------------------
// Point to pixel color splat axis unit
// Three-stage box test and linear color level mapping for one axis.
// ---------------------------------------------------------------------------
module ppcs_axis (
  input  logic                              clk,
  input  ppcs_pkg::stage_en_t               en,
  input  logic signed [ppcs_pkg::COORD_W-1:0] coord,
  input  logic signed [ppcs_pkg::COORD_W-1:0] lo,
  input  logic signed [ppcs_pkg::COORD_W-1:0] hi,
  input  logic [ppcs_pkg::SCALE_W-1:0]      scale,
  output logic                              outside,
  output logic [ppcs_pkg::LEVEL_W-1:0]      level
);
  import ppcs_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic                     pos1;
  logic [COORD_W-1:0]       mag1;
  logic                     pos2;
  logic [PRODUCT_W-1:0]     prod2;
  logic [LEVEL_W-1:0]       level_next;

  assign diff = DIFF_W'(coord) - DIFF_W'(lo);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      pos1    <= (diff > 0);
      mag1    <= diff[COORD_W-1:0];
      outside <= (coord < lo) || (coord > hi);
    end
    if (en.s2) begin
      pos2  <= pos1;
      prod2 <= PRODUCT_W'(mag1) * PRODUCT_W'(scale);
    end
    if (en.s3) begin
      level <= level_next;
    end
  end

  always_comb begin
    if (!pos2) begin
      level_next = LEVEL_MIN;
    end else if (prod2[PRODUCT_W-1:FRAC_SHIFT+LEVEL_W] != '0) begin
      level_next = LEVEL_MAX;
    end else begin
      level_next = prod2[FRAC_SHIFT+LEVEL_W-1:FRAC_SHIFT];
    end
  end

endmodule
